FILE: rtl/core/pcdea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdea_pkg
// Shared types and constants for the phase-cycled echo/antiecho DFT.
// ----------------------------------------------------------------------------
package pcdea_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TW_START,
      ST_DIV,
      ST_CORDIC,
      ST_MAC,
      ST_OUT
   } seq_state_type;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_N_PHASES  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ORDER = 4'd1;

   localparam int SAMPLE_W     = 32;
   localparam int ORDER_W      = 5;
   localparam int NPH_W        = 7;
   localparam int TURN_BITS    = 32;
   localparam int CORDIC_ITERS = 30;
   localparam int CORDIC_FRAC  = 30;
   localparam int CORDIC_XW    = 34;
   localparam int CORDIC_ZW    = 32;
   localparam int CORDIC_IW    = 5;
   localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [CORDIC_ZW-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

endpackage

FILE: rtl/core/pcdea_turn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdea_turn_div
// Bit-serial restoring divider: turn fraction floor(num * 2^32 / den).
// ----------------------------------------------------------------------------
module pcdea_turn_div #(
   parameter int NW = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [NW-1:0]                       num,
   input  logic [NW-1:0]                       den,
   output logic                                done,
   output logic [pcdea_pkg::TURN_BITS-1:0]     quot
);
   import pcdea_pkg::*;

   localparam int CW = $clog2(TURN_BITS);

   logic [NW-1:0]        rem_ff;
   logic [TURN_BITS-1:0] quot_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 run_ff;
   logic                 done_ff;
   logic [NW:0]          rem2;
   logic                 ge;

   always_comb begin
      rem2 = {rem_ff, 1'b0};
      ge   = (rem2 >= {1'b0, den});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == CW'(TURN_BITS - 1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         cnt_ff <= '0;
      end else if (run_ff) begin
         rem_ff  <= ge ? NW'(rem2 - {1'b0, den}) : rem2[NW-1:0];
         quot_ff <= {quot_ff[TURN_BITS-2:0], ge};
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: rtl/core/pcdea_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdea_cordic
// Iterative rotation CORDIC, one micro-rotation per cycle, twiddle output.
// ----------------------------------------------------------------------------
module pcdea_cordic #(
   parameter int TFB = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [pcdea_pkg::TURN_BITS-1:0]       turn,
   output logic                                  done,
   output logic signed [TFB+1:0]                 cos_q,
   output logic signed [TFB+1:0]                 sin_q
);
   import pcdea_pkg::*;

   localparam int TW = TFB + 2;
   localparam int SH = CORDIC_FRAC - TFB;
   localparam logic signed [CORDIC_XW-1:0] HALF = CORDIC_XW'(1) <<< (SH - 1);
   localparam logic signed [CORDIC_XW-1:0] ONE  = CORDIC_XW'(1) <<< TFB;

   logic signed [CORDIC_XW-1:0] x_ff, y_ff;
   logic signed [CORDIC_ZW-1:0] z_ff;
   logic [CORDIC_IW-1:0]        i_ff;
   logic [1:0]                  quad_ff;
   logic                        run_ff, fin_ff, done_ff;
   logic signed [TW-1:0]        cos_ff, sin_ff;
   logic signed [CORDIC_XW-1:0] dx, dy, cx, sy;
   logic signed [CORDIC_ZW-1:0] at;

   function automatic logic signed [TW-1:0] to_twiddle(input logic signed [CORDIC_XW-1:0] v);
      logic signed [CORDIC_XW-1:0] r;
      r = (v + HALF) >>> SH;
      if (r > ONE) r = ONE;
      if (r < -ONE) r = -ONE;
      return TW'(r);
   endfunction

   always_comb begin
      dx = y_ff >>> i_ff;
      dy = x_ff >>> i_ff;
      at = $signed(ATAN_TURNS[i_ff]);
      case (quad_ff)
         2'd0: begin cx = x_ff;  sy = y_ff;  end
         2'd1: begin cx = -y_ff; sy = x_ff;  end
         2'd2: begin cx = -x_ff; sy = -y_ff; end
         default: begin cx = y_ff; sy = -x_ff; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && i_ff == CORDIC_IW'(CORDIC_ITERS - 1)) begin
            run_ff <= 1'b0;
            fin_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= CORDIC_ZW'({2'b00, turn[TURN_BITS-3:0]});
         quad_ff <= turn[TURN_BITS-1:TURN_BITS-2];
         i_ff    <= '0;
      end else if (run_ff) begin
         if (!z_ff[CORDIC_ZW-1]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end
         i_ff <= i_ff + 1'b1;
      end
      if (fin_ff) begin
         cos_ff <= to_twiddle(cx);
         sin_ff <= -to_twiddle(sy);
      end
   end

   assign done  = done_ff;
   assign cos_q = cos_ff;
   assign sin_q = sin_ff;

endmodule

FILE: rtl/core/pcdea_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdea_mac
// Shared multiplier, four saturating 64-bit accumulators and output scaling.
// ----------------------------------------------------------------------------
module pcdea_mac #(
   parameter int TFB = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      clr,
   input  logic                                      start,
   input  logic signed [TFB+1:0]                     cos_q,
   input  logic signed [TFB+1:0]                     sin_q,
   input  logic signed [pcdea_pkg::SAMPLE_W-1:0]     a,
   input  logic signed [pcdea_pkg::SAMPLE_W-1:0]     b,
   output logic                                      done,
   output logic signed [pcdea_pkg::SAMPLE_W-1:0]     echo_real,
   output logic signed [pcdea_pkg::SAMPLE_W-1:0]     echo_imag,
   output logic signed [pcdea_pkg::SAMPLE_W-1:0]     antiecho_real,
   output logic signed [pcdea_pkg::SAMPLE_W-1:0]     antiecho_imag
);
   import pcdea_pkg::*;

   localparam int TW = TFB + 2;
   localparam int PW = SAMPLE_W + TW;

   logic [2:0]            k_ff;
   logic                  run_ff, done_ff;
   logic signed [PW-1:0]  p_ff [4];
   logic signed [63:0]    acc_ff [4];
   logic signed [TW-1:0]  mul_tw;
   logic signed [SAMPLE_W-1:0] mul_sm;
   logic signed [PW-1:0]  prod;
   logic signed [PW:0]    t_er, t_ei, t_ar, t_ai;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] acc,
                                                  input logic signed [PW:0] t);
      logic signed [64:0] sum;
      sum = 65'(acc) + 65'(t);
      if (sum[64] != sum[63])
         return sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return sum[63:0];
   endfunction

   function automatic logic [SAMPLE_W-1:0] finish(input logic signed [63:0] acc);
      logic        neg;
      logic [63:0] mag;
      neg = acc[63];
      mag = neg ? (64'd0 - acc) : acc;
      mag = mag >> TFB;
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      if (!neg && mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return neg ? (32'd0 - mag[31:0]) : mag[31:0];
   endfunction

   always_comb begin
      case (k_ff[1:0])
         2'd0: begin mul_tw = cos_q; mul_sm = a; end
         2'd1: begin mul_tw = sin_q; mul_sm = b; end
         2'd2: begin mul_tw = cos_q; mul_sm = b; end
         default: begin mul_tw = sin_q; mul_sm = a; end
      endcase
      prod = PW'(mul_tw) * PW'(mul_sm);
      t_er = (PW+1)'(p_ff[0]) + (PW+1)'(p_ff[1]);
      t_ei = (PW+1)'(p_ff[2]) - (PW+1)'(p_ff[3]);
      t_ar = (PW+1)'(p_ff[0]) - (PW+1)'(p_ff[1]);
      t_ai = (PW+1)'(p_ff[3]) + (PW+1)'(p_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && k_ff[2]) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         k_ff <= '0;
      end else if (run_ff) begin
         k_ff <= k_ff + 1'b1;
         if (!k_ff[2]) p_ff[k_ff[1:0]] <= prod;
      end
      if (clr) begin
         for (int i = 0; i < 4; i++) acc_ff[i] <= '0;
      end else if (run_ff && k_ff[2]) begin
         acc_ff[0] <= sat_add(acc_ff[0], t_er);
         acc_ff[1] <= sat_add(acc_ff[1], t_ei);
         acc_ff[2] <= sat_add(acc_ff[2], t_ar);
         acc_ff[3] <= sat_add(acc_ff[3], t_ai);
      end
   end

   assign done          = done_ff;
   assign echo_real     = finish(acc_ff[0]);
   assign echo_imag     = finish(acc_ff[1]);
   assign antiecho_real = finish(acc_ff[2]);
   assign antiecho_imag = finish(acc_ff[3]);

endmodule

FILE: rtl/core/phase_cycle_dft_echo_antiecho.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_cycle_dft_echo_antiecho
// Collects N phase-step samples and emits echo/antiecho DFT bins 0..max_order.
//
//   channel   ports                        handshake
//   request   start, busy, req_sample_*    start & !busy
//   response  rsp_valid, rsp_*             one-cycle strobe, no backpressure
//   csr       csr_valid/ready, index/wdata valid & ready
//
// A sample that does not close a group is stored and the block stays idle. A
// closing sample starts the transform: each phase step of each bin runs the
// serial turn divider, the CORDIC (30 iterations) and four passes of the
// shared multiplier. Busy stays high until the last bin is emitted.
// Reset clears the control state and loads the csr defaults; buffers are not
// cleared.
// ----------------------------------------------------------------------------
module phase_cycle_dft_echo_antiecho #(
   parameter int MAX_PHASES        = 64,
   parameter int TWIDDLE_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [pcdea_pkg::SAMPLE_W-1:0] req_sample_real,
   input  logic signed [pcdea_pkg::SAMPLE_W-1:0] req_sample_imag,
   output logic                                  rsp_valid,
   output logic [pcdea_pkg::ORDER_W-1:0]         rsp_order_index,
   output logic signed [pcdea_pkg::SAMPLE_W-1:0] rsp_echo_real,
   output logic signed [pcdea_pkg::SAMPLE_W-1:0] rsp_echo_imag,
   output logic signed [pcdea_pkg::SAMPLE_W-1:0] rsp_antiecho_real,
   output logic signed [pcdea_pkg::SAMPLE_W-1:0] rsp_antiecho_imag,
   output logic                                  rsp_last_order,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pcdea_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pcdea_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pcdea_pkg::*;

   localparam int AW  = $clog2(MAX_PHASES);
   localparam int NW  = AW + 1;
   localparam int TW  = TWIDDLE_FRAC_BITS + 2;

   seq_state_type state_ff, state_in;
   logic [AW-1:0] phase_ff, phase_in;
   logic [AW-1:0] l_ff, l_in, r_ff, r_in, qm_ff, qm_in;
   logic [ORDER_W-1:0] q_ff, q_in;
   logic [NPH_W-1:0]   n_phases_ff;
   logic [ORDER_W-1:0] max_order_ff;

   logic signed [SAMPLE_W-1:0] real_mem [MAX_PHASES];
   logic signed [SAMPLE_W-1:0] imag_mem [MAX_PHASES];
   logic signed [SAMPLE_W-1:0] rd_real_ff, rd_imag_ff;

   logic rsp_valid_ff;
   logic [ORDER_W-1:0] rsp_order_ff;
   logic signed [SAMPLE_W-1:0] rsp_er_ff, rsp_ei_ff, rsp_ar_ff, rsp_ai_ff;
   logic rsp_last_ff;

   logic [NW-1:0] n_eff, cnt_next, r_sum, qm_inc;
   logic accept, complete, last_l;
   logic div_start, cordic_start, mac_start, mac_clr, rd_en;
   logic div_done, cordic_done, mac_done;
   logic [TURN_BITS-1:0] turn;
   logic signed [TW-1:0] cos_q, sin_q;
   logic signed [SAMPLE_W-1:0] f_er, f_ei, f_ar, f_ai;

   assign busy      = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_comb begin
      if (n_phases_ff == '0)
         n_eff = NW'(1);
      else if (int'(n_phases_ff) > MAX_PHASES)
         n_eff = NW'(MAX_PHASES);
      else
         n_eff = NW'(n_phases_ff);
      cnt_next = {1'b0, phase_ff} + 1'b1;
      complete = (cnt_next >= n_eff);
      last_l   = (({1'b0, l_ff} + 1'b1) == n_eff);
      r_sum    = {1'b0, r_ff} + {1'b0, qm_ff};
      if (r_sum >= n_eff) r_sum = r_sum - n_eff;
      qm_inc   = {1'b0, qm_ff} + 1'b1;
      if (qm_inc == n_eff) qm_inc = '0;
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      qm_in        = qm_ff;
      div_start    = 1'b0;
      cordic_start = 1'b0;
      mac_start    = 1'b0;
      mac_clr      = 1'b0;
      rd_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (complete) begin
                  phase_in = '0;
                  q_in     = '0;
                  qm_in    = '0;
                  l_in     = '0;
                  r_in     = '0;
                  mac_clr  = 1'b1;
                  state_in = ST_TW_START;
               end else begin
                  phase_in = AW'(cnt_next);
               end
            end
         end
         ST_TW_START: begin
            div_start = 1'b1;
            rd_en     = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               cordic_start = 1'b1;
               state_in     = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               mac_start = 1'b1;
               state_in  = ST_MAC;
            end
         end
         ST_MAC: begin
            if (mac_done) begin
               if (last_l) begin
                  state_in = ST_OUT;
               end else begin
                  l_in     = l_ff + 1'b1;
                  r_in     = AW'(r_sum);
                  state_in = ST_TW_START;
               end
            end
         end
         ST_OUT: begin
            if (q_ff == max_order_ff) begin
               state_in = ST_IDLE;
            end else begin
               q_in     = q_ff + 1'b1;
               qm_in    = AW'(qm_inc);
               l_in     = '0;
               r_in     = '0;
               mac_clr  = 1'b1;
               state_in = ST_TW_START;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         n_phases_ff  <= NPH_W'(16);
         max_order_ff <= ORDER_W'(7);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= (state_ff == ST_OUT);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_N_PHASES:  n_phases_ff  <= csr_wdata[NPH_W-1:0];
               CSR_MAX_ORDER: max_order_ff <= csr_wdata[ORDER_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      l_ff  <= l_in;
      r_ff  <= r_in;
      q_ff  <= q_in;
      qm_ff <= qm_in;
      if (accept) begin
         real_mem[phase_ff] <= req_sample_real;
         imag_mem[phase_ff] <= req_sample_imag;
      end
      if (rd_en) begin
         rd_real_ff <= real_mem[l_ff];
         rd_imag_ff <= imag_mem[l_ff];
      end
      if (state_ff == ST_OUT) begin
         rsp_order_ff <= q_ff;
         rsp_er_ff    <= f_er;
         rsp_ei_ff    <= f_ei;
         rsp_ar_ff    <= f_ar;
         rsp_ai_ff    <= f_ai;
         rsp_last_ff  <= (q_ff == max_order_ff);
      end
   end

   pcdea_turn_div #(.NW(NW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({1'b0, r_ff}),
      .den   (n_eff),
      .done  (div_done),
      .quot  (turn)
   );

   pcdea_cordic #(.TFB(TWIDDLE_FRAC_BITS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .turn  (turn),
      .done  (cordic_done),
      .cos_q (cos_q),
      .sin_q (sin_q)
   );

   pcdea_mac #(.TFB(TWIDDLE_FRAC_BITS)) u_mac (
      .clock         (clock),
      .reset         (reset),
      .clr           (mac_clr),
      .start         (mac_start),
      .cos_q         (cos_q),
      .sin_q         (sin_q),
      .a             (rd_real_ff),
      .b             (rd_imag_ff),
      .done          (mac_done),
      .echo_real     (f_er),
      .echo_imag     (f_ei),
      .antiecho_real (f_ar),
      .antiecho_imag (f_ai)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_order_index   = rsp_order_ff;
   assign rsp_echo_real     = rsp_er_ff;
   assign rsp_echo_imag     = rsp_ei_ff;
   assign rsp_antiecho_real = rsp_ar_ff;
   assign rsp_antiecho_imag = rsp_ai_ff;
   assign rsp_last_order    = rsp_last_ff;

   a_last_ends_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_order |=> !rsp_valid && !busy)
      else $error("transaction after final bin");

   a_order_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_order_index <= max_order_ff))
      else $error("bin index beyond max_order");

   a_phase_residue: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ({1'b0, r_ff} < n_eff) && ({1'b0, qm_ff} < n_eff))
      else $error("phase residue out of range");

endmodule
